// ===== rtl/pl_pkg.sv =====
// Package for the positional list engine: sizes, codes, beat structs.
// No dependencies; used by positional_list_engine.sv and the testbench.
package pl_pkg;

  localparam int DEPTH     = 256;
  localparam int AW        = $clog2(DEPTH);
  localparam int CW        = $clog2(DEPTH + 1);
  localparam int POS_W     = 9;
  localparam int VAL_W     = 32;
  localparam int CNT_OUT_W = 9;
  localparam int XW        = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef enum logic [2:0] {
    ACT_GET = 3'd0,
    ACT_SET = 3'd1,
    ACT_INS = 3'd2,
    ACT_DEL = 3'd3,
    ACT_CLR = 3'd4
  } pl_act_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } pl_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GET,
    S_MOVE,
    S_EMIT
  } pl_state_t;

  typedef struct packed {
    logic [2:0]              action;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } pl_req_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] read_value;
    logic [CNT_OUT_W-1:0]    count;
    logic                    is_empty;
  } pl_rsp_t;

endpackage

// ===== rtl/pl_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module pl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/positional_list_engine.sv =====
// Positional list engine: get/set/insert/delete/clear on an ordered list in RAM.
// Set/clear/failed/other ops go straight to S_EMIT; a get passes through S_GET, and
// insert/delete shift elements one by one in S_MOVE (a tail insert moves none).
// req_stall stays high until the result loads, so the next beat is accepted only
// after the result has loaded. Reset clears the count; contents undefined.
// Depends on pl_pkg and pl_ram.
module positional_list_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  pl_pkg::pl_req_t req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output pl_pkg::pl_rsp_t rsp
);

  import pl_pkg::*;

  pl_state_t  state, state_next;
  pl_act_t    op, op_next;
  pl_status_t res_status, res_status_next;

  logic [AW-1:0]    idx, idx_next;
  logic [AW-1:0]    cur, cur_next;
  logic [AW-1:0]    wr_addr, wr_addr_next;
  logic [CW-1:0]    rem, rem_next;
  logic [CW-1:0]    cnt, cnt_next;
  logic [VAL_W-1:0] val, val_next;
  logic [VAL_W-1:0] res_value, res_value_next;
  logic             pend, pend_next;
  logic             first, first_next;
  logic             rsp_load;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [VAL_W-1:0] ram_wdata, ram_rdata;

  logic          req_acc;
  pl_act_t       act;
  logic [XW-1:0] pos_x, cnt_x;
  logic [AW-1:0] req_idx;
  logic          in_rng, ins_rng, full;

  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign act       = pl_act_t'(req.action);
  assign pos_x     = XW'(req.position);
  assign cnt_x     = XW'(cnt);
  assign req_idx   = AW'(pos_x - XW'(1));
  assign in_rng    = (req.position != '0) && (pos_x <= cnt_x);
  assign ins_rng   = (req.position != '0) && (pos_x <= cnt_x + XW'(1));
  assign full      = (cnt_x == XW'(DEPTH));

  pl_ram #(
    .WIDTH(VAL_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      pend  <= 1'b0;
      first <= 1'b0;
      rem   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      pend  <= pend_next;
      first <= first_next;
      rem   <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    op         <= op_next;
    idx        <= idx_next;
    cur        <= cur_next;
    wr_addr    <= wr_addr_next;
    val        <= val_next;
    res_status <= res_status_next;
    res_value  <= res_value_next;
  end

  always_comb begin
    state_next      = state;
    op_next         = op;
    idx_next        = idx;
    cur_next        = cur;
    wr_addr_next    = wr_addr;
    rem_next        = rem;
    cnt_next        = cnt;
    val_next        = val;
    res_status_next = res_status;
    res_value_next  = res_value;
    pend_next       = 1'b0;
    first_next      = 1'b0;
    rsp_load        = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = '0;
    ram_re          = 1'b0;
    ram_raddr       = '0;

    unique case (state)
      S_IDLE: begin
        if (req_acc) begin
          op_next         = act;
          idx_next        = req_idx;
          val_next        = req.value;
          res_status_next = ST_OK;
          res_value_next  = '0;
          state_next      = S_EMIT;
          unique case (act)
            ACT_GET: begin
              if (!in_rng) begin
                res_status_next = ST_RANGE;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = req_idx;
                state_next = S_GET;
              end
            end
            ACT_SET: begin
              if (!in_rng) begin
                res_status_next = ST_RANGE;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = req_idx;
                ram_wdata = req.value;
              end
            end
            ACT_INS: begin
              if (!ins_rng) begin
                res_status_next = ST_RANGE;
              end else if (full) begin
                res_status_next = ST_FULL;
              end else begin
                rem_next   = CW'(cnt_x - pos_x + XW'(1));
                cur_next   = AW'(cnt - CW'(1));
                state_next = S_MOVE;
              end
            end
            ACT_DEL: begin
              if (!in_rng) begin
                res_status_next = ST_RANGE;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = req_idx;
                pend_next  = 1'b1;
                first_next = 1'b1;
                cur_next   = req_idx + AW'(1);
                rem_next   = CW'(cnt_x - pos_x);
                state_next = S_MOVE;
              end
            end
            ACT_CLR: cnt_next = '0;
            default: ;
          endcase
        end
      end
      S_GET: begin
        res_value_next = ram_rdata;
        state_next     = S_EMIT;
      end
      S_MOVE: begin
        if (pend) begin
          if (first) begin
            res_value_next = ram_rdata;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = wr_addr;
            ram_wdata = ram_rdata;
          end
        end
        if (rem != '0) begin
          ram_re    = 1'b1;
          ram_raddr = cur;
          pend_next = 1'b1;
          rem_next  = rem - CW'(1);
          if (op == ACT_INS) begin
            wr_addr_next = cur + AW'(1);
            cur_next     = cur - AW'(1);
          end else begin
            wr_addr_next = cur - AW'(1);
            cur_next     = cur + AW'(1);
          end
        end else if (!pend) begin
          if (op == ACT_INS) begin
            ram_we    = 1'b1;
            ram_waddr = idx;
            ram_wdata = val;
            cnt_next  = cnt + CW'(1);
          end else begin
            cnt_next  = cnt - CW'(1);
          end
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.status     <= res_status;
      rsp.read_value <= res_value;
      rsp.count      <= CNT_OUT_W'(cnt);
      rsp.is_empty   <= (cnt == '0);
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    XW'(cnt) <= XW'(DEPTH))
    else $error("element count above depth");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_MOVE |-> rem <= cnt)
    else $error("move count exceeds element count");

  a_cnt_hold: assert property (@(posedge clk) disable iff (rst)
    state != S_MOVE && !req_acc |=> $stable(cnt))
    else $error("element count changed outside an operation");
`endif

endmodule

// ===== sim/tb_positional_list_engine.sv =====
// Self-checking testbench for positional_list_engine: directed and random list operations,
// with results predicted from a shadow copy of the list and checked beat by beat.
// Depends on pl_pkg and the engine RTL; stands alone otherwise.
module tb_positional_list_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import pl_pkg::*;

  localparam logic [2:0] ACT_RSVD5 = 3'd5;
  localparam logic [2:0] ACT_RSVD6 = 3'd6;
  localparam logic [2:0] ACT_RSVD7 = 3'd7;
  localparam int LAST_POS = (1 << POS_W) - 1;
  localparam logic signed [VAL_W-1:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] WORD_MIN = 32'sh8000_0000;

  logic    clk;
  logic    rst;
  logic    req_valid;
  logic    req_stall;
  pl_req_t req;
  logic    rsp_valid;
  logic    rsp_stall;
  pl_rsp_t rsp;

  logic signed [VAL_W-1:0] list_mem [DEPTH];
  int      list_len = 0;
  pl_rsp_t rsp_due [$];
  int      mismatches = 0;
  bit      calm = 1'b0;

  positional_list_engine dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #30ms;
    $display("positional_list_engine: mismatch");
    $finish;
  end

  function automatic pl_rsp_t apply_list_op(pl_req_t r);
    pl_rsp_t o;
    int      p;
    o = '0;
    p = r.position;
    case (r.action)
      ACT_GET: begin
        if (p < 1 || p > list_len) o.status = ST_RANGE;
        else o.read_value = list_mem[p-1];
      end
      ACT_SET: begin
        if (p < 1 || p > list_len) o.status = ST_RANGE;
        else list_mem[p-1] = r.value;
      end
      ACT_INS: begin
        if (p < 1 || p > list_len + 1) o.status = ST_RANGE;
        else if (list_len >= DEPTH) o.status = ST_FULL;
        else begin
          for (int i = list_len; i > p - 1; i--) list_mem[i] = list_mem[i-1];
          list_mem[p-1] = r.value;
          list_len++;
        end
      end
      ACT_DEL: begin
        if (p < 1 || p > list_len) o.status = ST_RANGE;
        else begin
          o.read_value = list_mem[p-1];
          for (int i = p - 1; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      ACT_CLR: list_len = 0;
      default: ;
    endcase
    o.count    = CNT_OUT_W'(list_len);
    o.is_empty = (list_len == 0);
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return -1;
      3: return 0;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_op(input logic [2:0] act, input int pos,
                         input logic signed [VAL_W-1:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{action: act, position: POS_W'(pos), value: val};
    do @(posedge clk); while (req_stall);
    rsp_due.push_back(apply_list_op(req));
  endtask

  // receiver back-pressure
  initial begin : stall_gen
    int hold;
    int r;
    rsp_stall = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) hold--;
      else if (calm) rsp_stall <= 1'b0;
      else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          rsp_stall <= 1'b0;
          hold = $urandom_range(0, 4);
        end else if (r < 94) begin
          rsp_stall <= 1'b1;
          hold = $urandom_range(0, 2);
        end else begin
          rsp_stall <= 1'b1;
          hold = $urandom_range(8, 40);
        end
      end
    end
  end

  always @(posedge clk) begin : rsp_check
    pl_rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (rsp_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result beat with nothing pending: %p", $time, rsp);
      end else begin
        want = rsp_due.pop_front();
        if (want.status !== rsp.status || want.read_value !== rsp.read_value ||
            want.count !== rsp.count || want.is_empty !== rsp.is_empty) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: exp status %0d value %0d count %0d empty %0d, got %0d %0d %0d %0d",
                     $time, want.status, want.read_value, want.count, want.is_empty,
                     rsp.status, rsp.read_value, rsp.count, rsp.is_empty);
        end
      end
    end
  end

  task automatic test_empty_list();
    send_op(ACT_GET, 1, 0);
    send_op(ACT_GET, 0, 0);
    send_op(ACT_SET, 1, WORD_MAX);
    send_op(ACT_DEL, 1, 0);
    send_op(ACT_CLR, 0, 0);
    send_op(ACT_INS, 0, 5);
    send_op(ACT_INS, 2, 5);
    send_op(ACT_INS, LAST_POS, -1);
    send_op(ACT_RSVD5, 1, 7);
    send_op(ACT_RSVD6, 0, -1);
    send_op(ACT_RSVD7, LAST_POS, WORD_MIN);
  endtask

  task automatic test_edge_positions();
    send_op(ACT_INS, 1, WORD_MAX);
    send_op(ACT_INS, 2, WORD_MIN);
    send_op(ACT_INS, 1, 0);
    send_op(ACT_INS, 4, -1);
    send_op(ACT_INS, 3, 32'sh5a5a_a5a5);
    send_op(ACT_GET, 1, 0);
    send_op(ACT_GET, 5, 0);
    send_op(ACT_GET, 6, 0);
    send_op(ACT_GET, LAST_POS, 0);
    send_op(ACT_SET, 5, 32'sh0123_4567);
    send_op(ACT_SET, 6, 7);
    send_op(ACT_SET, 0, 7);
    send_op(ACT_RSVD6, 3, 3);
    send_op(ACT_DEL, 5, 0);
    send_op(ACT_DEL, 1, 0);
    send_op(ACT_DEL, 2, 0);
    send_op(ACT_DEL, 0, 0);
    send_op(ACT_INS, LAST_POS, 1);
    send_op(ACT_GET, 2, 0);
    send_op(ACT_CLR, 0, 0);
    send_op(ACT_GET, 1, 0);
  endtask

  task automatic test_full_store();
    while (list_len < DEPTH) begin
      calm = (list_len < DEPTH / 2);
      send_op(ACT_INS, $urandom_range(1, list_len + 1), rand_word());
    end
    calm = 1'b0;
    send_op(ACT_INS, DEPTH, 11);
    send_op(ACT_INS, DEPTH + 1, 12);
    send_op(ACT_INS, DEPTH + 2, 13);
    send_op(ACT_INS, 0, 14);
    send_op(ACT_GET, DEPTH, 0);
    send_op(ACT_SET, DEPTH, WORD_MIN);
    send_op(ACT_GET, DEPTH, 0);
    send_op(ACT_DEL, DEPTH, 0);
    send_op(ACT_INS, DEPTH, WORD_MAX);
    send_op(ACT_DEL, 1, 0);
    repeat (30) send_op(ACT_DEL, $urandom_range(1, list_len), 0);
    send_op(ACT_CLR, 0, 0);
  endtask

  task automatic test_random_mix(input int n_ops);
    int         target;
    int         phase_left;
    int         r;
    int         pos;
    logic [2:0] act;
    target = 0;
    phase_left = 0;
    for (int k = 0; k < n_ops; k++) begin
      if (phase_left == 0) begin
        r = $urandom_range(0, 9);
        if (r < 7) target = $urandom_range(0, 24);
        else if (r < 9) target = $urandom_range(25, 120);
        else target = $urandom_range(200, DEPTH);
        phase_left = 40 + 2 * target;
        calm = ($urandom_range(0, 4) == 0);
      end
      phase_left--;
      r = $urandom_range(0, 99);
      if (r < 18) act = ACT_GET;
      else if (r < 32) act = ACT_SET;
      else if (r < 94) begin
        if (list_len < target) act = (r < 80) ? ACT_INS : ACT_DEL;
        else act = (r < 80) ? ACT_DEL : ACT_INS;
      end else if (r < 96) act = ACT_CLR;
      else act = 3'($urandom_range(ACT_RSVD5, ACT_RSVD7));
      r = $urandom_range(0, 99);
      if (r < 12) pos = $urandom_range(0, LAST_POS);
      else if (act == ACT_INS) pos = (r < 20) ? list_len + 1 : $urandom_range(1, list_len + 1);
      else if (list_len == 0) pos = $urandom_range(0, 2);
      else if (r < 20) pos = list_len;
      else pos = $urandom_range(1, list_len);
      send_op(act, pos, rand_word());
    end
    calm = 1'b0;
  endtask

  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_edge_positions();
    test_full_store();
    test_random_mix(1020);
    req_valid <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk);
    repeat (DEPTH + 16) @(posedge clk);
    if (mismatches == 0 && rsp_due.size() == 0) begin
      $display("positional_list_engine: match");
    end else begin
      $display("positional_list_engine: mismatch");
    end
    $finish;
  end

endmodule
